>>> src/utf8_to_utf16_validating_decoder_macros.svh
// Assertion macros shared by the decoder's checker.
`ifndef UTF8_TO_UTF16_VALIDATING_DECODER_MACROS_SVH
`define UTF8_TO_UTF16_VALIDATING_DECODER_MACROS_SVH

// Property checked at every rising clock edge unless rst is high.
`define U8U16_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Overlapping implication: ante at an edge implies cons at the same edge.
`define U8U16_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

>>> src/u8u16_pkg.sv
// Types and constants for the UTF-8 to UTF-16 decoder.
package u8u16_pkg;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_ILLEGAL   = 2'd1;
   localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

   localparam logic [7:0] LEAD_MIN   = 8'hC2;
   localparam logic [7:0] LEAD_MAX   = 8'hF4;
   localparam logic [7:0] LEAD_E0    = 8'hE0;
   localparam logic [7:0] LEAD_ED    = 8'hED;
   localparam logic [7:0] LEAD_F0    = 8'hF0;
   localparam logic [7:0] LEAD_F4    = 8'hF4;
   localparam logic [7:0] TRAIL_LO   = 8'h80;
   localparam logic [7:0] TRAIL_HI   = 8'hBF;
   localparam logic [7:0] E0_LO      = 8'hA0;
   localparam logic [7:0] ED_HI      = 8'h9F;
   localparam logic [7:0] F0_LO      = 8'h90;
   localparam logic [7:0] F4_HI      = 8'h8F;

   localparam logic [20:0] SUPP_BASE = 21'h010000;
   localparam logic [5:0]  HI_SURR   = 6'b110110;  // 0xD800 >> 10
   localparam logic [5:0]  LO_SURR   = 6'b110111;  // 0xDC00 >> 10

   typedef struct packed {
      logic [1:0]  owed;
      logic [20:0] point;
      logic [7:0]  lead;
      logic        first;
      logic        discard;
   } dec_state_type;

   typedef struct packed {
      logic [15:0] code_unit;
      logic [1:0]  status;
      logic        run_last;
      logic        string_end;
   } result_type;

endpackage

>>> src/utf8_to_utf16_validating_decoder.sv
// Streaming UTF-8 to UTF-16 decoder with strict validation, top level.
//
//   channel | dir | handshake            | payload
//   req     | in  | req_valid/req_ready  | req_byte_in[7:0], req_string_last
//   rsp     | out | rsp_valid/rsp_ready  | rsp_code_unit[15:0], rsp_status[1:0],
//           |     |                      | rsp_run_last, rsp_string_end
//
// One byte per cycle while the result buffer has room; a byte that completes a supplementary
// scalar loads both surrogates at once, and the next byte with a result waits for the low half.
// A req transfer reaches rsp through the input register and then the result buffer.
// Synchronous reset clears the sequence state and both buffers.
// A stalled rsp side fills the result buffer, then the input register, then drops req_ready.
module utf8_to_utf16_validating_decoder
   import u8u16_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_byte_in,
   input  logic        req_string_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_code_unit,
   output logic [1:0]  rsp_status,
   output logic        rsp_run_last,
   output logic        rsp_string_end
);

   logic          in_valid_ff, in_valid_in;
   logic [7:0]    in_byte_ff, in_byte_in;
   logic          in_last_ff, in_last_in;
   dec_state_type state_ff, state_in;
   dec_state_type step_nxt;
   logic [1:0]    step_count;
   result_type    step_res0;
   result_type    step_res1;
   logic          load_ok;
   logic          consume;

   u8u16_step u_step (
      .cur         (state_ff),
      .byte_in     (in_byte_ff),
      .string_last (in_last_ff),
      .nxt         (step_nxt),
      .count       (step_count),
      .res0        (step_res0),
      .res1        (step_res1)
   );

   // bytes that give no result never wait on the buffer
   assign consume   = in_valid_ff && ((step_count == 2'd0) || load_ok);
   assign req_ready = !in_valid_ff || consume;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_last_in  = in_last_ff;
      state_in    = state_ff;
      if (consume) begin
         in_valid_in = 1'b0;
         state_in    = step_nxt;
      end
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_byte_in;
         in_last_in  = req_string_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff    <= state_in;
      end
      in_byte_ff <= in_byte_in;
      in_last_ff <= in_last_in;
   end

   u8u16_outbuf u_outbuf (
      .clock          (clock),
      .reset          (reset),
      .load           (consume && (step_count != 2'd0)),
      .load_count     (step_count),
      .load_res0      (step_res0),
      .load_res1      (step_res1),
      .load_ok        (load_ok),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_code_unit  (rsp_code_unit),
      .rsp_status     (rsp_status),
      .rsp_run_last   (rsp_run_last),
      .rsp_string_end (rsp_string_end)
   );

endmodule

>>> src/u8u16_step.sv
// Combinational decode step: one byte against the sequence state.
module u8u16_step
   import u8u16_pkg::*;
(
   input  dec_state_type cur,
   input  logic [7:0]    byte_in,
   input  logic          string_last,
   output dec_state_type nxt,
   output logic [1:0]    count,
   output result_type    res0,
   output result_type    res1
);

   logic [7:0]  lo;
   logic [7:0]  hi;
   logic        trail_ok;
   logic        emit;
   logic        illegal;
   logic [20:0] pt;
   logic [20:0] acc;
   logic [20:0] offs;
   logic [1:0]  owed_left;

   always_comb begin
      lo = TRAIL_LO;
      hi = TRAIL_HI;
      if (cur.first) begin
         case (cur.lead)
            LEAD_E0: lo = E0_LO;
            LEAD_ED: hi = ED_HI;
            LEAD_F0: lo = F0_LO;
            LEAD_F4: hi = F4_HI;
            default: ;
         endcase
      end
      trail_ok = (byte_in >= lo) && (byte_in <= hi);
   end

   assign acc       = {cur.point[14:0], byte_in[5:0]};
   assign owed_left = cur.owed - 2'd1;
   assign offs      = pt - SUPP_BASE;

   always_comb begin
      nxt     = cur;
      count   = 2'd0;
      res0    = '0;
      res1    = '0;
      emit    = 1'b0;
      illegal = 1'b0;
      pt      = '0;
      if (cur.discard) begin
         if (string_last) nxt.discard = 1'b0;
      end else if (cur.owed == 2'd0) begin
         if (!byte_in[7]) begin
            emit = 1'b1;
            pt   = {13'd0, byte_in};
         end else if (byte_in < LEAD_MIN || byte_in > LEAD_MAX) begin
            illegal = 1'b1;
         end else if (string_last) begin
            nxt   = '0;
            count = 2'd1;
            res0  = '{code_unit: 16'd0, status: STATUS_TRUNCATED, run_last: 1'b1,
                      string_end: 1'b1};
         end else begin
            nxt.lead  = byte_in;
            nxt.first = 1'b1;
            case (byte_in[7:4]) inside
               4'hC, 4'hD: begin
                  nxt.owed  = 2'd1;
                  nxt.point = {16'd0, byte_in[4:0]};
               end
               4'hE: begin
                  nxt.owed  = 2'd2;
                  nxt.point = {17'd0, byte_in[3:0]};
               end
               default: begin
                  nxt.owed  = 2'd3;
                  nxt.point = {18'd0, byte_in[2:0]};
               end
            endcase
         end
      end else if (!trail_ok) begin
         illegal = 1'b1;
      end else if (owed_left == 2'd0) begin
         nxt  = '0;
         emit = 1'b1;
         pt   = acc;
      end else if (string_last) begin
         nxt   = '0;
         count = 2'd1;
         res0  = '{code_unit: 16'd0, status: STATUS_TRUNCATED, run_last: 1'b1,
                   string_end: 1'b1};
      end else begin
         nxt.point = acc;
         nxt.owed  = owed_left;
         nxt.first = 1'b0;
      end

      if (illegal) begin
         nxt         = '0;
         nxt.discard = !string_last;
         count       = 2'd1;
         res0        = '{code_unit: 16'd0, status: STATUS_ILLEGAL, run_last: 1'b1,
                         string_end: string_last};
      end

      if (emit) begin
         if (pt[20:16] == 5'd0) begin
            count = 2'd1;
            res0  = '{code_unit: pt[15:0], status: STATUS_OK, run_last: 1'b1,
                      string_end: string_last};
         end else begin
            // supplementary plane: surrogate pair, high half first
            count = 2'd2;
            res0  = '{code_unit: {HI_SURR, offs[19:10]}, status: STATUS_OK,
                      run_last: 1'b0, string_end: 1'b0};
            res1  = '{code_unit: {LO_SURR, offs[9:0]}, status: STATUS_OK,
                      run_last: 1'b1, string_end: string_last};
         end
      end
   end

endmodule

>>> src/u8u16_outbuf.sv
// Two-entry result buffer feeding the rsp channel.
module u8u16_outbuf
   import u8u16_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  logic [1:0]  load_count,
   input  result_type  load_res0,
   input  result_type  load_res1,
   output logic        load_ok,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_code_unit,
   output logic [1:0]  rsp_status,
   output logic        rsp_run_last,
   output logic        rsp_string_end
);

   logic [1:0] cnt_ff, cnt_in;
   result_type slot0_ff, slot0_in;
   result_type slot1_ff, slot1_in;
   logic       pop;

   assign pop     = (cnt_ff != 2'd0) && rsp_ready;
   // room for a fresh pair once the last held result leaves this cycle
   assign load_ok = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_ready);

   always_comb begin
      cnt_in   = cnt_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (load) begin
         cnt_in   = load_count;
         slot0_in = load_res0;
         slot1_in = load_res1;
      end else if (pop) begin
         cnt_in   = cnt_ff - 2'd1;
         slot0_in = slot1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign rsp_valid      = (cnt_ff != 2'd0);
   assign rsp_code_unit  = slot0_ff.code_unit;
   assign rsp_status     = slot0_ff.status;
   assign rsp_run_last   = slot0_ff.run_last;
   assign rsp_string_end = slot0_ff.string_end;

endmodule

>>> src/u8u16_checker.sv
// Port-level checker for the decoder, bound to the top level.
`include "utf8_to_utf16_validating_decoder_macros.svh"

module u8u16_checker
   import u8u16_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_code_unit,
   input logic [1:0]  rsp_status,
   input logic        rsp_run_last,
   input logic        rsp_string_end
);

   `U8U16_ASSERT_IMP(a_status_code, clock, reset, rsp_valid, (rsp_status == STATUS_OK) || (rsp_status == STATUS_ILLEGAL) || (rsp_status == STATUS_TRUNCATED), "rsp status out of range")
   `U8U16_ASSERT_IMP(a_err_zero, clock, reset, rsp_valid && (rsp_status != STATUS_OK), (rsp_code_unit == 16'd0) && rsp_run_last, "error result must be a lone zero unit")
   `U8U16_ASSERT_IMP(a_high_surr, clock, reset, rsp_valid && (rsp_status == STATUS_OK) && (rsp_code_unit[15:10] == HI_SURR), !rsp_run_last && !rsp_string_end, "high surrogate must be followed by its low half")
   `U8U16_ASSERT_IMP(a_trunc_end, clock, reset, rsp_valid && (rsp_status == STATUS_TRUNCATED), rsp_string_end, "truncation must close the string")
   `U8U16_ASSERT_IMP(a_rsp_hold, clock, reset, $past(rsp_valid && !rsp_ready) && !$past(reset), rsp_valid && $stable(rsp_code_unit) && $stable(rsp_status), "stalled rsp changed")

endmodule

bind utf8_to_utf16_validating_decoder u8u16_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_code_unit  (rsp_code_unit),
   .rsp_status     (rsp_status),
   .rsp_run_last   (rsp_run_last),
   .rsp_string_end (rsp_string_end)
);
